[sv/graph_reachability_connectivity_check_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the graph reachability / connectivity check core
// Shared concurrent assertion forms, reset-qualified on an active-low reset.
// ----------------------------------------------------------------------------
`ifndef GRAPH_REACHABILITY_CONNECTIVITY_CHECK_CORE_MACROS_SVH
`define GRAPH_REACHABILITY_CONNECTIVITY_CHECK_CORE_MACROS_SVH

// same-cycle implication
`define GRCC_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("grcc: assertion failed");

// next-cycle implication
`define GRCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("grcc: assertion failed");

`endif

[sv/grcc_pkg.sv]
// ----------------------------------------------------------------------------
// grcc_pkg
// Types, codes and helper functions of the reachability check core.
// ----------------------------------------------------------------------------
`default_nettype none

package grcc_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VTX_W        = $clog2(MAX_VERTICES + 1);
    localparam int ROW_W        = MAX_VERTICES;
    localparam int ROW_AW       = $clog2(MAX_VERTICES);
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 16;
    localparam int OUT_PAD_W    = OUT_DATA_W - (2 + 1 + VTX_W);

    // item actions
    localparam logic [1:0] ACT_SET   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_CHECK = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_RANGE  = 2'd1;
    localparam logic [1:0] STAT_ABSENT = 2'd2;

    typedef struct packed {
        logic [1:0]       status;
        logic             connected;
        logic [VTX_W-1:0] reached_count;
    } t_result;

    // vertex count in use: 0 acts as 1, values above the maximum saturate
    function automatic logic [VTX_W-1:0] active_count(input logic [VTX_W-1:0] vc);
        logic [VTX_W-1:0] n;
        n = vc;
        if (vc == '0) begin
            n = VTX_W'(1);
        end
        if (int'(vc) > MAX_VERTICES) begin
            n = VTX_W'(MAX_VERTICES);
        end
        return n;
    endfunction

    function automatic logic [ROW_W-1:0] low_mask(input logic [VTX_W-1:0] n);
        logic [ROW_W-1:0] m;
        for (int i = 0; i < ROW_W; i++) begin
            m[i] = (i < int'(n));
        end
        return m;
    endfunction

endpackage

`default_nettype wire

[sv/graph_reachability_connectivity_check_core.sv]
// ----------------------------------------------------------------------------
// graph_reachability_connectivity_check_core
// Directed graph store with arc set/clear and reachability/connectivity check.
// ----------------------------------------------------------------------------
// The core holds a directed graph over vertices 1..vertex_count as a 64 x 64
// adjacency bit matrix in a synchronous RAM (row v-1 = outgoing arcs of v).
// Each input transaction sets an arc, clears an arc, or checks whether every
// vertex in use is reachable from a start vertex; each gives exactly one
// result transaction. Set/clear is a read-modify-write of one row: the row
// is read on acceptance, written back in S_ARC unless a clear finds no arc,
// and the result is offered from S_DONE. Out-of-range vertices and the
// unused action give a result in the cycle after acceptance. A check walks
// the reached vertices one RAM read per cycle through the single read port
// and ends once no vertex is pending and no row read is in flight. One
// transaction is in flight at a time; the next is accepted as soon as the
// result has moved to the output register, even while that register still
// waits for the sink. Rows never written since reset read as empty through
// per-row valid flags, so no clearing pass runs. vertex_count is written
// through the cfg channel; the user must do so only while idle (unchecked).
// ----------------------------------------------------------------------------
`default_nettype none

module graph_reachability_connectivity_check_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config: vertex_count
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [grcc_pkg::VTX_W-1:0]         i_cfg_data,
    // input stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [grcc_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,  // action[1:0], from_vertex[8:2], to_vertex[15:9]
    // result stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [grcc_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata   // status[1:0], connected[2], reached_count[9:3], zero pad
);

    logic [grcc_pkg::VTX_W-1:0]   r_vertex_count;
    logic                         r_out_valid;
    grcc_pkg::t_result            r_out;

    logic                         w_rd_en, w_wr_en;
    logic [grcc_pkg::ROW_AW-1:0]  w_rd_addr, w_wr_addr;
    logic [grcc_pkg::ROW_W-1:0]   w_rd_data, w_wr_data;
    logic                         w_res_valid, w_res_ready;
    grcc_pkg::t_result            w_res;

    // register keeps the written bits; clamping happens where it is used
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= grcc_pkg::VTX_W'(grcc_pkg::MAX_VERTICES);
        end else if (i_cfg_valid) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    grcc_ram #(
        .WIDTH (grcc_pkg::ROW_W),
        .DEPTH (grcc_pkg::MAX_VERTICES)
    ) u_adj_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    grcc_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (i_s_axis_tvalid),
        .o_item_ready   (o_s_axis_tready),
        .i_action       (i_s_axis_tdata[1:0]),
        .i_from_vertex  (i_s_axis_tdata[8:2]),
        .i_to_vertex    (i_s_axis_tdata[15:9]),
        .i_vertex_count (r_vertex_count),
        .o_rd_en        (w_rd_en),
        .o_rd_addr      (w_rd_addr),
        .i_rd_data      (w_rd_data),
        .o_wr_en        (w_wr_en),
        .o_wr_addr      (w_wr_addr),
        .o_wr_data      (w_wr_data),
        .o_res_valid    (w_res_valid),
        .i_res_ready    (w_res_ready),
        .o_res          (w_res)
    );

    // output register: loads when empty or being drained this cycle
    assign w_res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {grcc_pkg::OUT_PAD_W'(0), r_out.reached_count,
                              r_out.connected, r_out.status};

endmodule

`default_nettype wire

[sv/grcc_ram.sv]
// ----------------------------------------------------------------------------
// grcc_ram
// Generic single-write, single-read synchronous RAM, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module grcc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[sv/grcc_ctrl.sv]
// ----------------------------------------------------------------------------
// grcc_ctrl
// Sequencer: arc read-modify-write and worklist reachability expansion
// over the adjacency RAM.
// ----------------------------------------------------------------------------
`default_nettype none

`include "graph_reachability_connectivity_check_core_macros.svh"

module grcc_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item side
    input  logic                           i_item_valid,
    output logic                           o_item_ready,
    input  logic [1:0]                     i_action,
    input  logic [grcc_pkg::VTX_W-1:0]     i_from_vertex,
    input  logic [grcc_pkg::VTX_W-1:0]     i_to_vertex,
    input  logic [grcc_pkg::VTX_W-1:0]     i_vertex_count,
    // adjacency RAM
    output logic                           o_rd_en,
    output logic [grcc_pkg::ROW_AW-1:0]    o_rd_addr,
    input  logic [grcc_pkg::ROW_W-1:0]     i_rd_data,
    output logic                           o_wr_en,
    output logic [grcc_pkg::ROW_AW-1:0]    o_wr_addr,
    output logic [grcc_pkg::ROW_W-1:0]     o_wr_data,
    // result side
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output grcc_pkg::t_result              o_res
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ARC  = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    logic [1:0]                      r_action, n_action;
    logic [grcc_pkg::ROW_AW-1:0]     r_row, n_row;
    logic [grcc_pkg::ROW_AW-1:0]     r_col, n_col;
    logic [grcc_pkg::VTX_W-1:0]      r_n, n_n;
    logic [grcc_pkg::ROW_W-1:0]      r_valid_mask, n_valid_mask;
    logic [grcc_pkg::ROW_W-1:0]      r_reach, n_reach;
    logic [grcc_pkg::ROW_W-1:0]      r_frontier, n_frontier;
    logic [grcc_pkg::VTX_W-1:0]      r_count, n_count;
    logic                            r_inflight, n_inflight;
    grcc_pkg::t_result               r_res, n_res;
    logic [grcc_pkg::ROW_W-1:0]      r_row_valid;
    logic                            r_rd_ok;

    logic [grcc_pkg::VTX_W-1:0]      w_n;
    logic                            w_from_ok, w_to_ok, w_accept;
    logic [grcc_pkg::VTX_W-1:0]      w_from_dec, w_to_dec;
    logic [grcc_pkg::ROW_W-1:0]      w_row, w_col_bit, w_new, w_pick_bit;
    logic [grcc_pkg::ROW_AW-1:0]     w_pick_idx;
    logic                            w_any;

    // decode of the item at the input
    assign w_n        = grcc_pkg::active_count(i_vertex_count);
    assign w_from_ok  = (i_from_vertex != '0) && (i_from_vertex <= w_n);
    assign w_to_ok    = (i_to_vertex != '0) && (i_to_vertex <= w_n);
    assign w_from_dec = i_from_vertex - grcc_pkg::VTX_W'(1);
    assign w_to_dec   = i_to_vertex - grcc_pkg::VTX_W'(1);
    assign w_accept   = (r_state == S_IDLE) && i_item_valid;

    // row as seen by the logic: never-written rows read as empty
    assign w_row      = r_rd_ok ? i_rd_data : '0;
    assign w_col_bit  = grcc_pkg::ROW_W'(1) << r_col;
    assign w_new      = r_inflight ? (w_row & r_valid_mask & ~r_reach) : '0;

    // lowest pending vertex
    assign w_any      = |r_frontier;
    assign w_pick_bit = r_frontier & (~r_frontier + grcc_pkg::ROW_W'(1));
    always_comb begin
        w_pick_idx = '0;
        for (int i = grcc_pkg::ROW_W - 1; i >= 0; i--) begin
            if (r_frontier[i]) begin
                w_pick_idx = grcc_pkg::ROW_AW'(i);
            end
        end
    end

    assign o_item_ready = (r_state == S_IDLE);
    assign o_rd_addr    = (r_state == S_SCAN) ? w_pick_idx : w_from_dec[grcc_pkg::ROW_AW-1:0];
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res        = r_res;

    always_comb begin
        n_state      = r_state;
        n_action     = r_action;
        n_row        = r_row;
        n_col        = r_col;
        n_n          = r_n;
        n_valid_mask = r_valid_mask;
        n_reach      = r_reach;
        n_frontier   = r_frontier;
        n_count      = r_count;
        n_inflight   = 1'b0;
        n_res        = r_res;
        o_rd_en      = 1'b0;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_row;
        o_wr_data    = w_row | w_col_bit;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_action     = i_action;
                    n_row        = w_from_dec[grcc_pkg::ROW_AW-1:0];
                    n_col        = w_to_dec[grcc_pkg::ROW_AW-1:0];
                    n_n          = w_n;
                    n_valid_mask = grcc_pkg::low_mask(w_n);
                    n_res        = '{status: grcc_pkg::STAT_OK, connected: 1'b0,
                                     reached_count: '0};
                    n_state      = S_DONE;
                    if (i_action == grcc_pkg::ACT_SET || i_action == grcc_pkg::ACT_CLEAR) begin
                        if (w_from_ok && w_to_ok) begin
                            o_rd_en = 1'b1;
                            n_state = S_ARC;
                        end else begin
                            n_res.status = grcc_pkg::STAT_RANGE;
                        end
                    end else if (i_action == grcc_pkg::ACT_CHECK) begin
                        if (w_from_ok) begin
                            n_reach    = grcc_pkg::ROW_W'(1) << w_from_dec[grcc_pkg::ROW_AW-1:0];
                            n_frontier = grcc_pkg::ROW_W'(1) << w_from_dec[grcc_pkg::ROW_AW-1:0];
                            n_count    = '0;
                            n_state    = S_SCAN;
                        end else begin
                            n_res.status = grcc_pkg::STAT_RANGE;
                        end
                    end
                end
            end
            S_ARC: begin
                n_state = S_DONE;
                if (r_action == grcc_pkg::ACT_SET) begin
                    o_wr_en   = 1'b1;
                    o_wr_data = w_row | w_col_bit;
                end else if ((w_row & w_col_bit) == '0) begin
                    n_res.status = grcc_pkg::STAT_ABSENT;
                end else begin
                    o_wr_en   = 1'b1;
                    o_wr_data = w_row & ~w_col_bit;
                end
            end
            S_SCAN: begin
                // issue one row read per cycle, merge the row returned from the last one
                o_rd_en    = w_any;
                n_inflight = w_any;
                n_frontier = (r_frontier & ~w_pick_bit) | w_new;
                n_reach    = r_reach | w_new;
                n_count    = r_count + grcc_pkg::VTX_W'(w_any);
                if (!w_any && !r_inflight) begin
                    n_res   = '{status: grcc_pkg::STAT_OK, connected: (r_count == r_n),
                                reached_count: r_count};
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inflight  <= 1'b0;
            r_row_valid <= '0;
            r_reach     <= '0;
            r_frontier  <= '0;
        end else begin
            r_state    <= n_state;
            r_inflight <= n_inflight;
            r_reach    <= n_reach;
            r_frontier <= n_frontier;
            if (o_wr_en) begin
                r_row_valid[o_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_row        <= n_row;
        r_col        <= n_col;
        r_n          <= n_n;
        r_valid_mask <= n_valid_mask;
        r_count      <= n_count;
        r_res        <= n_res;
        r_rd_ok      <= r_row_valid[o_rd_addr];
    end

    `GRCC_ASSERT_IMPLIES(a_wr_only_in_arc, i_clk, i_rst_n, o_wr_en, r_state == S_ARC)
    `GRCC_ASSERT_NEXT(a_arc_one_cycle, i_clk, i_rst_n, r_state == S_ARC, r_state == S_DONE)
    `GRCC_ASSERT_IMPLIES(a_reach_in_use, i_clk, i_rst_n, r_state == S_SCAN, (r_reach & ~r_valid_mask) == '0)
    `GRCC_ASSERT_IMPLIES(a_count_bound, i_clk, i_rst_n, r_state == S_DONE, r_res.reached_count <= r_n)
    `GRCC_ASSERT_IMPLIES(a_conn_ok, i_clk, i_rst_n, (r_state == S_DONE) && r_res.connected, r_res.status == grcc_pkg::STAT_OK)

endmodule

`default_nettype wire
